[rtl/core/lpsd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpsd_pkg: shared types and codes for the LED PWM shadow/flush core
// Request kinds, register indexes, reset values and the config register layout.
// ----------------------------------------------------------------------------
package lpsd_pkg;

	localparam int unsigned LEVEL_W = 8;
	localparam int unsigned ADDR_W  = 8;
	localparam int unsigned LED_W   = 4;
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 8;

	typedef enum logic [KIND_W-1:0] {
		KIND_SET_COLOR = 2'd0,
		KIND_SET_ALL   = 2'd1,
		KIND_COMMIT    = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PWM_BASE = 1'd0,
		CFG_UPDATE   = 1'd1
	} cfg_idx_t;

	localparam logic [ADDR_W-1:0] PWM_BASE_RESET = 8'd1;
	localparam logic [ADDR_W-1:0] UPDATE_RESET   = 8'd109;
	localparam logic [LEVEL_W-1:0] UPDATE_DATA   = 8'h00;

	// color slot inside one LED
	localparam logic [1:0] COLOR_RED   = 2'd0;
	localparam logic [1:0] COLOR_GREEN = 2'd1;
	localparam logic [1:0] COLOR_BLUE  = 2'd2;

	typedef struct packed {
		logic [ADDR_W-1:0] pwm_base;
		logic [ADDR_W-1:0] update;
	} cfg_t;

endpackage

`default_nettype wire

[rtl/core/lpsd_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpsd_if: request and write-beat channels
// Valid/ready channels carrying request items and register write beats.
// ----------------------------------------------------------------------------
interface lpsd_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [lpsd_pkg::KIND_W-1:0]   kind;
	logic [lpsd_pkg::LED_W-1:0]    led_number;
	logic [lpsd_pkg::LEVEL_W-1:0]  red_level;
	logic [lpsd_pkg::LEVEL_W-1:0]  green_level;
	logic [lpsd_pkg::LEVEL_W-1:0]  blue_level;

	modport source (output valid, kind, led_number, red_level, green_level, blue_level,
		input ready);
	modport sink (input valid, kind, led_number, red_level, green_level, blue_level,
		output ready);
endinterface

interface lpsd_wr_if;
	logic                          valid;
	logic                          ready;
	logic [lpsd_pkg::ADDR_W-1:0]   write_address;
	logic [lpsd_pkg::LEVEL_W-1:0]  write_data;
	logic                          last_write;

	modport source (output valid, write_address, write_data, last_write, input ready);
	modport sink (input valid, write_address, write_data, last_write, output ready);
endinterface

`default_nettype wire

[rtl/core/lpsd_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpsd_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lpsd_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 36
) (
	input  wire                                        clk,
	input  wire                                        we,
	input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire [WIDTH-1:0]                            wdata,
	input  wire                                        re,
	input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/core/lpsd_seq.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpsd_seq: channel sequencer
// Walks the channels through the shadow RAM for set requests (one per cycle)
// and commits (output stalls hold it), keeps dirty/written flags, output beat.
// ----------------------------------------------------------------------------
module lpsd_seq #(
	parameter int unsigned LED_COUNT = 12
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire lpsd_pkg::cfg_t  cfg,
	lpsd_cmd_if.sink             cmd,
	lpsd_wr_if.source            wr
);
	import lpsd_pkg::*;

	localparam int unsigned CH    = 3 * LED_COUNT;
	localparam int unsigned CH_W  = $clog2(CH + 1);
	localparam int unsigned IDX_W = $clog2(CH);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SET,
		ST_DRAIN,
		ST_SCAN,
		ST_FETCH,
		ST_UPDATE
	} state_t;

	state_t               state_q;
	logic [CH_W-1:0]      ch_q;
	logic [1:0]           color_q;
	logic                 all_q;
	logic [LEVEL_W-1:0]   red_q, green_q, blue_q;
	logic [CH-1:0]        dirty_q;
	logic [CH-1:0]        written_q;

	logic                 s1_valid_q;
	logic [IDX_W-1:0]     ch_s1;
	logic [LEVEL_W-1:0]   lvl_s1;

	logic                 out_valid_q;
	logic [ADDR_W-1:0]    out_addr_q;
	logic [LEVEL_W-1:0]   out_data_q;
	logic                 out_last_q;

	logic [IDX_W-1:0]     idx;
	logic                 scan_end;
	logic                 set_end;
	logic                 slot_free;
	logic                 ram_re;
	logic [LEVEL_W-1:0]   ram_rdata;
	logic [LEVEL_W-1:0]   old_level;
	logic [LEVEL_W-1:0]   cur_level;
	logic [ADDR_W-1:0]    start_wide;
	logic                 led_ok;

	assign idx       = ch_q[IDX_W-1:0];
	assign scan_end  = (ch_q == CH_W'(CH));
	assign set_end   = all_q ? (ch_q == CH_W'(CH - 1)) : (color_q == COLOR_BLUE);
	assign slot_free = !out_valid_q || wr.ready;
	assign old_level = written_q[ch_s1] ? ram_rdata : '0;
	assign led_ok    = ({2'b00, cmd.led_number} < 6'(LED_COUNT));
	// first channel of an LED is led * 3
	assign start_wide = {3'b000, cmd.led_number, 1'b0} + {4'b0000, cmd.led_number};

	always_comb begin
		unique case (color_q)
			COLOR_RED:   cur_level = red_q;
			COLOR_GREEN: cur_level = green_q;
			COLOR_BLUE:  cur_level = blue_q;
			default:     cur_level = red_q;
		endcase
	end

	assign ram_re = (state_q == ST_SET) ||
		((state_q == ST_SCAN) && !scan_end && dirty_q[idx]);

	lpsd_ram #(
		.WIDTH (LEVEL_W),
		.DEPTH (CH)
	) u_shadow (
		.clk   (clk),
		.we    (s1_valid_q),
		.waddr (ch_s1),
		.wdata (lvl_s1),
		.re    (ram_re),
		.raddr (idx),
		.rdata (ram_rdata)
	);

	assign cmd.ready        = (state_q == ST_IDLE);
	assign wr.valid         = out_valid_q;
	assign wr.write_address = out_addr_q;
	assign wr.write_data    = out_data_q;
	assign wr.last_write    = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ch_q        <= '0;
			color_q     <= COLOR_RED;
			all_q       <= 1'b0;
			dirty_q     <= '0;
			written_q   <= '0;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr.ready) begin
				out_valid_q <= 1'b0;
			end

			// finish the read-compare-write of the channel issued last cycle
			if (s1_valid_q) begin
				written_q[ch_s1] <= 1'b1;
				if (old_level != lvl_s1) begin
					dirty_q[ch_s1] <= 1'b1;
				end
			end

			unique case (state_q)
				ST_IDLE: begin
					s1_valid_q <= 1'b0;
					if (cmd.valid) begin
						red_q   <= cmd.red_level;
						green_q <= cmd.green_level;
						blue_q  <= cmd.blue_level;
						color_q <= COLOR_RED;
						unique case (cmd.kind)
							KIND_SET_COLOR: begin
								all_q <= 1'b0;
								ch_q  <= CH_W'(start_wide);
								if (led_ok) begin
									state_q <= ST_SET;
								end
							end
							KIND_SET_ALL: begin
								all_q   <= 1'b1;
								ch_q    <= '0;
								state_q <= ST_SET;
							end
							KIND_COMMIT: begin
								ch_q    <= '0;
								state_q <= ST_SCAN;
							end
							default: ;
						endcase
					end
				end
				ST_SET: begin
					s1_valid_q <= 1'b1;
					ch_s1      <= idx;
					lvl_s1     <= cur_level;
					ch_q       <= ch_q + 1'b1;
					color_q    <= (color_q == COLOR_BLUE) ? COLOR_RED : color_q + 1'b1;
					if (set_end) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					s1_valid_q <= 1'b0;
					state_q    <= ST_IDLE;
				end
				ST_SCAN: begin
					if (scan_end) begin
						state_q <= ST_UPDATE;
					end else if (dirty_q[idx]) begin
						state_q <= ST_FETCH;
					end else begin
						ch_q <= ch_q + 1'b1;
					end
				end
				ST_FETCH: begin
					// hold the read data until the output slot frees up
					if (slot_free) begin
						out_valid_q  <= 1'b1;
						out_addr_q   <= cfg.pwm_base + ADDR_W'({ch_q, 1'b0});
						out_data_q   <= written_q[idx] ? ram_rdata : '0;
						out_last_q   <= 1'b0;
						dirty_q[idx] <= 1'b0;
						ch_q         <= ch_q + 1'b1;
						state_q      <= ST_SCAN;
					end
				end
				ST_UPDATE: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_addr_q  <= cfg.update;
						out_data_q  <= UPDATE_DATA;
						out_last_q  <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/core/led_pwm_shadow_dirty_flush_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// led_pwm_shadow_dirty_flush_core: LED PWM shadow store with dirty flush
// Holds the configuration registers and the channel sequencer.
// ----------------------------------------------------------------------------
//  port    dir   beat contents
//  cmd     in    kind, led_number, red/green/blue_level
//  wr      out   write_address, write_data, last_write
//  cfg_*   in    index 0 pwm_base_address, index 1 update_address
//
//  A commit walks every channel through the one shadow RAM read port,
//  scanning each clean channel and fetching each dirty one into a write
//  beat, then runs the end check and the update write.
//  Reset clears shadow written flags and dirty flags at once; no sweep.
//  An output stall holds the sequencer on the pending beat.
// ----------------------------------------------------------------------------
module led_pwm_shadow_dirty_flush_core #(
	parameter int unsigned LED_COUNT = 12
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_we,
	input  wire [lpsd_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire [lpsd_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	lpsd_cmd_if.sink                             cmd,
	lpsd_wr_if.source                            wr
);
	import lpsd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pwm_base <= PWM_BASE_RESET;
			cfg_q.update   <= UPDATE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_PWM_BASE: cfg_q.pwm_base <= cfg_wdata;
				CFG_UPDATE:   cfg_q.update   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	lpsd_seq #(
		.LED_COUNT (LED_COUNT)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.cmd    (cmd),
		.wr     (wr)
	);

endmodule

`default_nettype wire

[dv/led_pwm_shadow_dirty_flush_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_pwm_shadow_dirty_flush_core_test: shadow store and dirty flush check
// Sends set-color, set-all and commit requests with random gaps and output
// stalls under several address settings. Every register write beat is
// predicted from a local shadow copy and compared field by field.
// ----------------------------------------------------------------------------

localparam int unsigned LED_COUNT     = 12;
localparam int unsigned CHANNEL_COUNT = 3 * LED_COUNT;

typedef struct packed {
	logic [lpsd_pkg::ADDR_W-1:0]  address;
	logic [lpsd_pkg::LEVEL_W-1:0] data;
	logic                         last;
} reg_write_t;

class flush_scoreboard;
	logic [lpsd_pkg::LEVEL_W-1:0] duty [CHANNEL_COUNT];
	bit                           dirty [CHANNEL_COUNT];
	logic [lpsd_pkg::ADDR_W-1:0]  pwm_base;
	logic [lpsd_pkg::ADDR_W-1:0]  update_reg;
	reg_write_t                   pending_writes [$];
	int unsigned                  errors;
	int unsigned                  requests;
	int unsigned                  commits;
	int unsigned                  beats;

	function new();
		for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
			duty[ch] = '0;
			dirty[ch] = 1'b0;
		end
		pwm_base = lpsd_pkg::PWM_BASE_RESET;
		update_reg = lpsd_pkg::UPDATE_RESET;
		errors = 0;
		requests = 0;
		commits = 0;
		beats = 0;
	endfunction

	function void write_reg(lpsd_pkg::cfg_idx_t idx, logic [lpsd_pkg::CFG_DATA_W-1:0] value);
		case (idx)
			lpsd_pkg::CFG_PWM_BASE: pwm_base = value;
			lpsd_pkg::CFG_UPDATE:   update_reg = value;
			default: ;
		endcase
	endfunction

	// dirty stays set until flushed, even if a later set restores the value
	function void set_led(int unsigned led, logic [7:0] red, logic [7:0] green,
		logic [7:0] blue);
		logic [7:0]  lv [3];
		int unsigned ch;
		lv[0] = red;
		lv[1] = green;
		lv[2] = blue;
		for (int c = 0; c < 3; c++) begin
			ch = led * 3 + c;
			if (duty[ch] != lv[c])
				dirty[ch] = 1'b1;
			duty[ch] = lv[c];
		end
	endfunction

	function void note_request(logic [lpsd_pkg::KIND_W-1:0] kind,
		logic [lpsd_pkg::LED_W-1:0] led, logic [7:0] red, logic [7:0] green,
		logic [7:0] blue);
		reg_write_t w;
		requests++;
		case (kind)
			lpsd_pkg::KIND_SET_COLOR: begin
				if (led < LED_COUNT)
					set_led(led, red, green, blue);
			end
			lpsd_pkg::KIND_SET_ALL: begin
				for (int i = 0; i < LED_COUNT; i++)
					set_led(i, red, green, blue);
			end
			lpsd_pkg::KIND_COMMIT: begin
				commits++;
				for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
					if (dirty[ch]) begin
						w.address = pwm_base + 8'(2 * ch);
						w.data = duty[ch];
						w.last = 1'b0;
						pending_writes.push_back(w);
						dirty[ch] = 1'b0;
					end
				end
				w.address = update_reg;
				w.data = lpsd_pkg::UPDATE_DATA;
				w.last = 1'b1;
				pending_writes.push_back(w);
			end
			default: ;
		endcase
	endfunction

	function void check_beat(logic [7:0] address, logic [7:0] data, logic last);
		reg_write_t want;
		beats++;
		if (pending_writes.size() == 0) begin
			errors++;
			$error("unexpected write beat: address %0d data %0d last %0b",
				address, data, last);
			return;
		end
		want = pending_writes.pop_front();
		if (address !== want.address) begin
			errors++;
			$error("write_address: expected %0d, got %0d", want.address, address);
		end
		if (data !== want.data) begin
			errors++;
			$error("write_data: expected %0d, got %0d", want.data, data);
		end
		if (last !== want.last) begin
			errors++;
			$error("last_write: expected %0b, got %0b", want.last, last);
		end
	endfunction

	function bit idle();
		return pending_writes.size() == 0;
	endfunction
endclass

module led_pwm_shadow_dirty_flush_core_test;
	import lpsd_pkg::*;

	localparam int unsigned SETTLE_CYCLES = 3 * LED_COUNT + 8;
	localparam int unsigned RANDOM_ITEMS  = 450;
	localparam int unsigned PHASES        = 6;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	bit                    steady = 1'b0;
	int unsigned           settings = 0;
	flush_scoreboard       sb;

	lpsd_cmd_if cmd_ch();
	lpsd_wr_if  wr_ch();

	led_pwm_shadow_dirty_flush_core #(
		.LED_COUNT(LED_COUNT)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.cmd      (cmd_ch),
		.wr       (wr_ch)
	);

	always #5 clk = ~clk;

	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (steady || roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [7:0] pick_level();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'hFF;
			// reuse a stored duty so unchanged and restored values come up often
			2, 3: return sb.duty[$urandom_range(0, CHANNEL_COUNT - 1)];
			default: return 8'($urandom());
		endcase
	endfunction

	// output back-pressure: short stalls mostly, a few long ones
	initial begin : wr_ready_drive
		int unsigned hold;
		hold = 0;
		wr_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
				wr_ch.ready <= 1'b0;
			end else if (!steady && $urandom_range(0, 99) < 25) begin
				hold = pick_gap();
				wr_ch.ready <= 1'b0;
			end else begin
				wr_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && wr_ch.valid && wr_ch.ready)
			sb.check_beat(wr_ch.write_address, wr_ch.write_data, wr_ch.last_write);
	end

	task automatic send_request(input logic [KIND_W-1:0] kind, input logic [LED_W-1:0] led,
		input logic [7:0] red, input logic [7:0] green, input logic [7:0] blue);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_ch.kind <= kind;
		cmd_ch.led_number <= led;
		cmd_ch.red_level <= red;
		cmd_ch.green_level <= green;
		cmd_ch.blue_level <= blue;
		cmd_ch.valid <= 1'b1;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		sb.note_request(kind, led, red, green, blue);
		@(negedge clk);
	endtask

	// hold off new requests until every write beat is out, then let set work finish
	task automatic wait_for_flush();
		cmd_ch.valid <= 1'b0;
		while (!sb.idle())
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		sb.write_reg(idx, value);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_addresses(input logic [7:0] base, input logic [7:0] update);
		wait_for_flush();
		write_register(CFG_PWM_BASE, base);
		write_register(CFG_UPDATE, update);
		settings++;
	endtask

	task automatic run_random_phase(input int unsigned count);
		int unsigned       done;
		int unsigned       pick;
		logic [KIND_W-1:0] kind;
		logic [LED_W-1:0]  led;
		done = 0;
		while (done < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 4)
				kind = KIND_UNUSED;
			else if (pick < 52)
				kind = KIND_SET_COLOR;
			else if (pick < 62)
				kind = KIND_SET_ALL;
			else
				kind = KIND_COMMIT;
			if ($urandom_range(0, 9) == 0)
				led = LED_W'($urandom_range(LED_COUNT, 15));
			else
				led = LED_W'($urandom_range(0, LED_COUNT - 1));
			send_request(kind, led, pick_level(), pick_level(), pick_level());
			done++;
		end
	endtask

	initial begin
		int unsigned base;
		int unsigned update;
		cmd_ch.valid = 1'b0;
		cmd_ch.kind = '0;
		cmd_ch.led_number = '0;
		cmd_ch.red_level = '0;
		cmd_ch.green_level = '0;
		cmd_ch.blue_level = '0;
		sb = new();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty commit under reset addresses, then edge LEDs and ignored requests
		send_request(KIND_COMMIT, 4'd0, 8'h00, 8'h00, 8'h00);
		send_request(KIND_SET_COLOR, 4'd0, 8'hFF, 8'h00, 8'h80);
		send_request(KIND_SET_COLOR, 4'd11, 8'hFF, 8'hFF, 8'hFF);
		send_request(KIND_SET_COLOR, 4'd12, 8'h12, 8'h34, 8'h56);
		send_request(KIND_SET_COLOR, 4'd15, 8'hAA, 8'h55, 8'h01);
		send_request(KIND_UNUSED, 4'd3, 8'h77, 8'h77, 8'h77);
		send_request(KIND_COMMIT, 4'd15, 8'hFF, 8'hFF, 8'hFF);
		// change then restore: channels stay dirty
		send_request(KIND_SET_COLOR, 4'd5, 8'h55, 8'hAA, 8'h01);
		send_request(KIND_SET_COLOR, 4'd5, 8'h00, 8'h00, 8'h00);
		send_request(KIND_COMMIT, 4'd7, 8'h00, 8'hFF, 8'h00);
		send_request(KIND_SET_ALL, 4'd15, 8'hFF, 8'h00, 8'hAA);
		send_request(KIND_SET_ALL, 4'd0, 8'hFF, 8'h00, 8'hAA);
		send_request(KIND_COMMIT, 4'd0, 8'h00, 8'h00, 8'h00);
		send_request(KIND_SET_ALL, 4'd9, 8'hFF, 8'h00, 8'hAA);
		send_request(KIND_COMMIT, 4'd0, 8'h00, 8'h00, 8'h00);
		send_request(KIND_SET_ALL, 4'd0, 8'h00, 8'h00, 8'h00);
		send_request(KIND_SET_COLOR, 4'd7, 8'hFF, 8'hFF, 8'hFF);
		send_request(KIND_COMMIT, 4'd0, 8'h00, 8'h00, 8'h00);
		// address wrap at the top of the range
		set_addresses(8'hFF, 8'h00);
		send_request(KIND_SET_ALL, 4'd0, 8'hFF, 8'hFF, 8'hFF);
		send_request(KIND_COMMIT, 4'd0, 8'h00, 8'h00, 8'h00);
		set_addresses(8'h00, 8'hFF);
		send_request(KIND_SET_ALL, 4'd0, 8'h01, 8'h80, 8'h7F);
		send_request(KIND_COMMIT, 4'd0, 8'h00, 8'h00, 8'h00);

		for (int p = 0; p < PHASES; p++) begin
			base = $urandom_range(0, 255);
			update = $urandom_range(0, 255);
			if (p == 0) begin
				base = PWM_BASE_RESET;
				update = UPDATE_RESET;
			end else if (p == 2) begin
				base = 254;
				update = 1;
			end
			set_addresses(8'(base), 8'(update));
			steady = (p == 3);
			run_random_phase(RANDOM_ITEMS / PHASES);
		end
		wait_for_flush();

		$display("Covered %0d requests and %0d commits, %0d write beats checked",
			sb.requests, sb.commits, sb.beats);
		$display("across %0d address settings with gaps and output stalls", settings);
		if (sb.errors == 0 && sb.idle())
			$display("PASS led_pwm_shadow_dirty_flush_core");
		else
			$display("FAIL led_pwm_shadow_dirty_flush_core");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("FAIL led_pwm_shadow_dirty_flush_core");
		$finish;
	end

endmodule
